// ----- design/crs_pkg.sv -----
`timescale 1ns / 1ps

package crs_pkg;

    // Table size when the top level is not overridden.
    localparam int MAX_POINTS_DEF = 64;

    // Output queue: holds finished results while the sink stalls.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Field widths.
    localparam int IDX_W   = 6;
    localparam int PT_W    = 24;
    localparam int T_W     = 18;
    localparam int MODE_W  = 2;
    localparam int CNT_W   = 7;
    localparam int OUT_W   = 32;
    localparam int IN_DW   = 80;
    localparam int OUT_DW  = 64;

    // Internal arithmetic widths.
    localparam int SC_W    = 24;  // clamped t times (n - 3)
    localparam int E_W     = 56;  // exact weight, Q48 of twice the weight
    localparam int C_W     = 37;  // rounded weight, Q32
    localparam int PP_W    = 43;  // one partial product
    localparam int ACC_W   = 62;  // product and sum width

    // Item kinds (tuser bit 0 on the input side).
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Result selection.
    localparam logic [MODE_W-1:0] MODE_POINT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SLOPE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CURVE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Register map, indexed by paddr[2].
    localparam logic REG_POINT_COUNT = 1'b0;

endpackage

// ----- design/catmull_rom_spline_eval.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tdata: index, x, y, t, mode; tuser: op
// m_axis    out        m_axis_tvalid/tready      tdata: out_x, out_y; tuser: flags
// apb       in         psel/penable/pwrite/pready register point_count at byte 0
//
// One transaction per clock while s_axis_tready is high; an evaluation is written
// to the eight-entry output queue after the pipeline steps (scale, table read,
// cube, weights, multiply, sum), and a load only writes the table, with no result.
// s_axis_tready drops while eight evaluations are in flight or queued, so the
// pipeline never stalls. Synchronous active-low reset clears point_count,
// valid bits and queue pointers, not the point table.

module catmull_rom_spline_eval #(
    parameter int MAX_POINTS = crs_pkg::MAX_POINTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [5:0] point_index, [29:6] point_x, [53:30] point_y,
    // [71:54] param_t, [73:72] mode, [79:74] zero
    input  logic [crs_pkg::IN_DW-1:0]   s_axis_tdata,
    // [0] op
    input  logic                        s_axis_tuser,

    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [31:0] out_x, [63:32] out_y
    output logic [crs_pkg::OUT_DW-1:0]  m_axis_tdata,
    // [0] saturated, [1] too_few_points
    output logic [1:0]                  m_axis_tuser,

    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = crs_pkg::CNT_W;
    localparam int PW = crs_pkg::PT_W;
    localparam int EW = crs_pkg::E_W;
    localparam int AW = crs_pkg::ACC_W;
    localparam logic signed [EW-1:0] ONE48  = EW'(64'sh1_0000_0000_0000);
    localparam logic signed [EW-1:0] RND17  = EW'(64'sh1_0000);
    localparam logic signed [AW-1:0] RND32  = AW'(64'sh8000_0000);
    localparam logic signed [AW-1:0] SAT_HI = AW'(64'sh7FFF_FFFF);
    localparam logic signed [AW-1:0] SAT_LO = -AW'(64'sh8000_0000);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [CW-1:0] r_point_count;
    logic          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & (paddr[2] == crs_pkg::REG_POINT_COUNT);
    assign prdata   = (paddr[2] == crs_pkg::REG_POINT_COUNT) ? 32'(r_point_count) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (w_cfg_wr) begin
            r_point_count <= pwdata[CW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Input unpack and flow control
    // ---------------------------------------------------------------
    logic [crs_pkg::FIFO_CW-1:0] r_pending;
    logic                        w_in_acc;
    logic                        w_in_op;
    logic [crs_pkg::IDX_W-1:0]   w_in_idx;
    logic signed [PW-1:0]        w_in_x;
    logic signed [PW-1:0]        w_in_y;
    logic signed [crs_pkg::T_W-1:0] w_in_t;
    logic [crs_pkg::MODE_W-1:0]  w_in_mode;

    assign s_axis_tready = (r_pending < crs_pkg::FIFO_CW'(crs_pkg::FIFO_DEPTH));
    assign w_in_acc  = s_axis_tvalid & s_axis_tready;
    assign w_in_op   = s_axis_tuser;
    assign w_in_idx  = s_axis_tdata[5:0];
    assign w_in_x    = s_axis_tdata[29:6];
    assign w_in_y    = s_axis_tdata[53:30];
    assign w_in_t    = s_axis_tdata[71:54];
    assign w_in_mode = s_axis_tdata[73:72];

    // ---------------------------------------------------------------
    // Stage 0 (comb): clamp t, clamp count, scale by (n - 3)
    // ---------------------------------------------------------------
    logic [CW-1:0]              n_s1_n;
    logic                       n_s1_few;
    logic [16:0]                w_tcl;
    logic [CW-1:0]              w_nm3;
    logic [crs_pkg::SC_W-1:0]   n_s1_sc;

    always_comb begin
        n_s1_n   = (32'(r_point_count) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : r_point_count;
        n_s1_few = (n_s1_n < CW'(4));
        if (w_in_t[17]) begin
            w_tcl = 17'd0;
        end else if (w_in_t[16:0] > 17'd65536) begin
            w_tcl = 17'd65536;
        end else begin
            w_tcl = w_in_t[16:0];
        end
        w_nm3   = n_s1_few ? '0 : n_s1_n - CW'(3);
        n_s1_sc = crs_pkg::SC_W'(w_tcl) * crs_pkg::SC_W'(w_nm3);
    end

    // ---------------------------------------------------------------
    // Stage 1: index selection, u^2, table write / read
    // ---------------------------------------------------------------
    logic                        r_s1_vld;
    logic                        r_s1_op;
    logic [crs_pkg::IDX_W-1:0]   r_s1_idx;
    logic signed [PW-1:0]        r_s1_x;
    logic signed [PW-1:0]        r_s1_y;
    logic [crs_pkg::SC_W-1:0]    r_s1_sc;
    logic [CW-1:0]               r_s1_n;
    logic [crs_pkg::MODE_W-1:0]  r_s1_mode;
    logic                        r_s1_few;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op   <= w_in_op;
        r_s1_idx  <= w_in_idx;
        r_s1_x    <= w_in_x;
        r_s1_y    <= w_in_y;
        r_s1_sc   <= n_s1_sc;
        r_s1_n    <= n_s1_n;
        r_s1_mode <= w_in_mode;
        r_s1_few  <= n_s1_few;
    end

    logic [CW-1:0]  w_seg;
    logic [CW-1:0]  w_nm1;
    logic [CW-1:0]  w_seg2;
    logic [15:0]    w_u;
    logic [CW-1:0]  w_ix [4];
    logic [IW-1:0]  w_raddr [4];
    logic [31:0]    n_s2_u2;
    logic           w_we;
    logic [IW-1:0]  w_waddr;

    always_comb begin
        w_seg   = r_s1_sc[22:16];
        w_u     = r_s1_sc[15:0];
        w_nm1   = r_s1_n - CW'(1);
        w_seg2  = w_seg + CW'(2);
        // neighbors clamped at both ends of the table
        w_ix[0] = (w_seg != '0) ? w_seg - CW'(1) : '0;
        w_ix[1] = w_seg;
        w_ix[2] = w_seg + CW'(1);
        w_ix[3] = (w_seg2 < w_nm1) ? w_seg2 : w_nm1;
        for (int k = 0; k < 4; k++) begin
            w_raddr[k] = IW'(w_ix[k]);
        end
        n_s2_u2 = 32'(w_u) * 32'(w_u);
        w_we    = r_s1_vld & (r_s1_op == crs_pkg::OP_LOAD)
                  & (32'(r_s1_idx) < 32'(MAX_POINTS));
        w_waddr = IW'(r_s1_idx);
    end

    // Four copies of the table, one per tap, so all four points are read
    // in the same cycle. Loads write all copies from this stage, which keeps
    // loads and evaluations in order.
    logic [2*PW-1:0] r_mem [4][MAX_POINTS];
    logic [2*PW-1:0] r_s2_pt [4];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (w_we) begin
                r_mem[k][w_waddr] <= {r_s1_y, r_s1_x};
            end
            r_s2_pt[k] <= r_mem[k][w_raddr[k]];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: u^3
    // ---------------------------------------------------------------
    logic                        r_s2_vld;
    logic                        r_s2_zero;
    logic                        r_s2_few;
    logic [crs_pkg::MODE_W-1:0]  r_s2_mode;
    logic [15:0]                 r_s2_u;
    logic [31:0]                 r_s2_u2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld & (r_s1_op == crs_pkg::OP_EVAL);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_zero <= r_s1_few | (r_s1_mode == crs_pkg::MODE_UNUSED);
        r_s2_few  <= r_s1_few;
        r_s2_mode <= r_s1_mode;
        r_s2_u    <= w_u;
        r_s2_u2   <= n_s2_u2;
    end

    logic [47:0] n_s3_u3;
    assign n_s3_u3 = 48'(r_s2_u2) * 48'(r_s2_u);

    // ---------------------------------------------------------------
    // Stage 3: basis weights, exact then rounded to Q32
    // ---------------------------------------------------------------
    logic                        r_s3_vld;
    logic                        r_s3_zero;
    logic                        r_s3_few;
    logic [crs_pkg::MODE_W-1:0]  r_s3_mode;
    logic [15:0]                 r_s3_u;
    logic [31:0]                 r_s3_u2;
    logic [47:0]                 r_s3_u3;
    logic [2*PW-1:0]             r_s3_pt [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_zero <= r_s2_zero;
        r_s3_few  <= r_s2_few;
        r_s3_mode <= r_s2_mode;
        r_s3_u    <= r_s2_u;
        r_s3_u2   <= r_s2_u2;
        r_s3_u3   <= n_s3_u3;
        r_s3_pt   <= r_s2_pt;
    end

    logic signed [EW-1:0]        w_a;   // u^3
    logic signed [EW-1:0]        w_b;   // u^2 * 2^16
    logic signed [EW-1:0]        w_c;   // u * 2^32
    logic signed [EW-1:0]        w_e [4];
    logic signed [EW-1:0]        w_er [4];
    logic signed [crs_pkg::C_W-1:0] n_s4_c [4];

    always_comb begin
        w_a = $signed(EW'(r_s3_u3));
        w_b = $signed(EW'(r_s3_u2) << 16);
        w_c = $signed(EW'(r_s3_u) << 32);
        case (r_s3_mode)
            crs_pkg::MODE_POINT: begin
                w_e[0] = -w_a + 2 * w_b - w_c;
                w_e[1] = 3 * w_a - 5 * w_b + 2 * ONE48;
                w_e[2] = -3 * w_a + 4 * w_b + w_c;
                w_e[3] = w_a - w_b;
            end
            crs_pkg::MODE_SLOPE: begin
                w_e[0] = -3 * w_b + 4 * w_c - ONE48;
                w_e[1] = 9 * w_b - 10 * w_c;
                w_e[2] = -9 * w_b + 8 * w_c + ONE48;
                w_e[3] = 3 * w_b - 2 * w_c;
            end
            crs_pkg::MODE_CURVE: begin
                w_e[0] = -6 * w_c + 4 * ONE48;
                w_e[1] = 18 * w_c - 10 * ONE48;
                w_e[2] = -18 * w_c + 8 * ONE48;
                w_e[3] = 6 * w_c - 2 * ONE48;
            end
            default: begin
                for (int k = 0; k < 4; k++) begin
                    w_e[k] = '0;
                end
            end
        endcase
        // round to nearest, ties up: add half then floor
        for (int k = 0; k < 4; k++) begin
            w_er[k]   = w_e[k] + RND17;
            n_s4_c[k] = w_er[k][17 +: crs_pkg::C_W];
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: weight x point, split into 19x24 partial products
    // ---------------------------------------------------------------
    logic                           r_s4_vld;
    logic                           r_s4_zero;
    logic                           r_s4_few;
    logic signed [crs_pkg::C_W-1:0] r_s4_c [4];
    logic [2*PW-1:0]                r_s4_pt [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_zero <= r_s3_zero;
        r_s4_few  <= r_s3_few;
        r_s4_c    <= n_s4_c;
        r_s4_pt   <= r_s3_pt;
    end

    localparam int PPW = crs_pkg::PP_W;
    logic signed [18:0]  w_chi [4];
    logic signed [18:0]  w_clo [4];
    logic signed [PW-1:0] w_px [4];
    logic signed [PW-1:0] w_py [4];
    logic signed [PPW-1:0] n_s5_hx [4];
    logic signed [PPW-1:0] n_s5_lx [4];
    logic signed [PPW-1:0] n_s5_hy [4];
    logic signed [PPW-1:0] n_s5_ly [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_chi[k]   = r_s4_c[k][36:18];
            w_clo[k]   = $signed({1'b0, r_s4_c[k][17:0]});
            w_px[k]    = r_s4_pt[k][PW-1:0];
            w_py[k]    = r_s4_pt[k][2*PW-1:PW];
            n_s5_hx[k] = PPW'(w_chi[k]) * PPW'(w_px[k]);
            n_s5_lx[k] = PPW'(w_clo[k]) * PPW'(w_px[k]);
            n_s5_hy[k] = PPW'(w_chi[k]) * PPW'(w_py[k]);
            n_s5_ly[k] = PPW'(w_clo[k]) * PPW'(w_py[k]);
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: recombine partials, pairwise sums
    // ---------------------------------------------------------------
    logic                  r_s5_vld;
    logic                  r_s5_zero;
    logic                  r_s5_few;
    logic signed [PPW-1:0] r_s5_hx [4];
    logic signed [PPW-1:0] r_s5_lx [4];
    logic signed [PPW-1:0] r_s5_hy [4];
    logic signed [PPW-1:0] r_s5_ly [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_zero <= r_s4_zero;
        r_s5_few  <= r_s4_few;
        r_s5_hx   <= n_s5_hx;
        r_s5_lx   <= n_s5_lx;
        r_s5_hy   <= n_s5_hy;
        r_s5_ly   <= n_s5_ly;
    end

    logic signed [AW-1:0] w_prx [4];
    logic signed [AW-1:0] w_pry [4];
    logic signed [AW-1:0] n_s6_ax;
    logic signed [AW-1:0] n_s6_bx;
    logic signed [AW-1:0] n_s6_ay;
    logic signed [AW-1:0] n_s6_by;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_prx[k] = (AW'(r_s5_hx[k]) <<< 18) + AW'(r_s5_lx[k]);
            w_pry[k] = (AW'(r_s5_hy[k]) <<< 18) + AW'(r_s5_ly[k]);
        end
        n_s6_ax = w_prx[0] + w_prx[1];
        n_s6_bx = w_prx[2] + w_prx[3];
        n_s6_ay = w_pry[0] + w_pry[1];
        n_s6_by = w_pry[2] + w_pry[3];
    end

    // ---------------------------------------------------------------
    // Stage 6: final sum, round to Q16, saturate
    // ---------------------------------------------------------------
    logic                 r_s6_vld;
    logic                 r_s6_zero;
    logic                 r_s6_few;
    logic signed [AW-1:0] r_s6_ax;
    logic signed [AW-1:0] r_s6_bx;
    logic signed [AW-1:0] r_s6_ay;
    logic signed [AW-1:0] r_s6_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else begin
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_zero <= r_s5_zero;
        r_s6_few  <= r_s5_few;
        r_s6_ax   <= n_s6_ax;
        r_s6_bx   <= n_s6_bx;
        r_s6_ay   <= n_s6_ay;
        r_s6_by   <= n_s6_by;
    end

    localparam int OW = crs_pkg::OUT_W;
    logic signed [AW-1:0] w_sx;
    logic signed [AW-1:0] w_sy;
    logic signed [AW-1:0] w_rx;
    logic signed [AW-1:0] w_ry;
    logic                 w_sat_x;
    logic                 w_sat_y;
    logic [OW-1:0]        w_ox;
    logic [OW-1:0]        w_oy;
    logic [OW*2+1:0]      w_push_data;

    always_comb begin
        w_sx = r_s6_ax + r_s6_bx + RND32;
        w_sy = r_s6_ay + r_s6_by + RND32;
        w_rx = w_sx >>> 32;
        w_ry = w_sy >>> 32;
        w_sat_x = (w_rx > SAT_HI) || (w_rx < SAT_LO);
        w_sat_y = (w_ry > SAT_HI) || (w_ry < SAT_LO);
        if (w_rx > SAT_HI) begin
            w_ox = SAT_HI[OW-1:0];
        end else if (w_rx < SAT_LO) begin
            w_ox = SAT_LO[OW-1:0];
        end else begin
            w_ox = w_rx[OW-1:0];
        end
        if (w_ry > SAT_HI) begin
            w_oy = SAT_HI[OW-1:0];
        end else if (w_ry < SAT_LO) begin
            w_oy = SAT_LO[OW-1:0];
        end else begin
            w_oy = w_ry[OW-1:0];
        end
        // too few points or unused mode: all zero, too_few flag only
        if (r_s6_zero) begin
            w_push_data = {r_s6_few, 1'b0, {OW{1'b0}}, {OW{1'b0}}};
        end else begin
            w_push_data = {1'b0, w_sat_x | w_sat_y, w_oy, w_ox};
        end
    end

    // ---------------------------------------------------------------
    // Output queue and outstanding-evaluation count
    // ---------------------------------------------------------------
    localparam int FAW = crs_pkg::FIFO_AW;
    localparam int FCW = crs_pkg::FIFO_CW;
    logic [OW*2+1:0] r_fifo [crs_pkg::FIFO_DEPTH];
    logic [FAW-1:0]  r_wr_ptr;
    logic [FAW-1:0]  r_rd_ptr;
    logic [FCW-1:0]  r_fifo_cnt;
    logic            w_pop;
    logic            w_eval_acc;

    assign m_axis_tvalid = (r_fifo_cnt != '0);
    assign m_axis_tdata  = r_fifo[r_rd_ptr][OW*2-1:0];
    assign m_axis_tuser  = r_fifo[r_rd_ptr][OW*2+1:OW*2];
    assign w_pop         = m_axis_tvalid & m_axis_tready;
    assign w_eval_acc    = w_in_acc & (w_in_op == crs_pkg::OP_EVAL);

    always_ff @(posedge i_clk) begin
        if (r_s6_vld) begin
            r_fifo[r_wr_ptr] <= w_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_pending  <= '0;
        end else begin
            if (r_s6_vld) begin
                r_wr_ptr <= r_wr_ptr + FAW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FAW'(1);
            end
            case ({r_s6_vld, w_pop})
                2'b10:   r_fifo_cnt <= r_fifo_cnt + FCW'(1);
                2'b01:   r_fifo_cnt <= r_fifo_cnt - FCW'(1);
                default: r_fifo_cnt <= r_fifo_cnt;
            endcase
            // evaluations accepted but not yet taken downstream
            case ({w_eval_acc, w_pop})
                2'b10:   r_pending <= r_pending + FCW'(1);
                2'b01:   r_pending <= r_pending - FCW'(1);
                default: r_pending <= r_pending;
            endcase
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int     TABLE_SIZE    = crs_pkg::MAX_POINTS_DEF;
    localparam int     SETTLE_CYCLES = 12;    // six-stage pipe plus output queue slack
    localparam int     SINK_HOLD     = 300;   // long back-pressure burst, in cycles
    localparam longint ONE16         = 64'sd65536;
    localparam longint ONE32         = 64'sd1 << 32;
    localparam longint ONE48         = 64'sd1 << 48;
    localparam longint SAT_MAX       = 64'sd2147483647;
    localparam longint SAT_MIN       = -64'sd2147483648;

    // One input transaction, unpacked into its fields.
    typedef struct packed {
        logic                              op;
        logic [crs_pkg::IDX_W-1:0]         idx;
        logic signed [crs_pkg::PT_W-1:0]   px;
        logic signed [crs_pkg::PT_W-1:0]   py;
        logic signed [crs_pkg::T_W-1:0]    tp;
        logic [crs_pkg::MODE_W-1:0]        sel;
    } t_spline_item;

    // One result transaction.
    typedef struct packed {
        logic signed [crs_pkg::OUT_W-1:0]  rx;
        logic signed [crs_pkg::OUT_W-1:0]  ry;
        logic                              sat;
        logic                              few;
    } t_curve_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;

    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [crs_pkg::IN_DW-1:0]     s_axis_tdata = '0;
    logic                          s_axis_tuser = 1'b0;

    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [crs_pkg::OUT_DW-1:0]    m_axis_tdata;
    logic [1:0]                    m_axis_tuser;

    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [2:0]                    paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // Stimulus waiting for the driver, and curve results waiting for the sink.
    t_spline_item         item_queue [$];
    t_curve_result        expected_curve [$];

    // Shadow copy of the block state used by the predictor.
    int                   shadow_x [TABLE_SIZE];
    int                   shadow_y [TABLE_SIZE];
    int                   shadow_count = 0;

    int                   error_count = 0;
    logic                 calm = 1'b0;       // no random idling on either side
    logic                 hold_req = 1'b0;   // ask the sink for one long stall
    logic                 hold_taken = 1'b0;
    int                   hold_left = 0;
    t_spline_item         in_flight;

    catmull_rom_spline_eval u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round to nearest, ties up, by an arithmetic shift. Done on an offset
    // unsigned value so the floor is the same for both signs.
    function automatic longint round_shift(longint v, int sh);
        longint unsigned bias;
        longint unsigned w;
        bias = 64'h4000_0000_0000_0000;
        w = v;
        w = w + bias + (64'd1 << (sh - 1));
        return longint'(w >> sh) - longint'(bias >> sh);
    endfunction

    function automatic t_curve_result spline_predict(t_spline_item it);
        t_curve_result r;
        longint n, t, sc, seg, u, u2, u3, sx, sy;
        longint coef [4];
        longint k [4];
        r = '0;
        n = longint'((shadow_count > TABLE_SIZE) ? TABLE_SIZE : shadow_count);
        if (n < 4) begin
            r.few = 1'b1;
        end else if (it.sel != crs_pkg::MODE_UNUSED) begin
            t = longint'($signed(it.tp));
            if (t < 0) t = 0;
            if (t > ONE16) t = ONE16;
            sc  = t * (n - 3);
            seg = sc >>> 16;
            u   = sc & 64'hFFFF;
            u2  = u * u;
            u3  = u2 * u;
            // Twice the basis weight, exact in Q48.
            case (it.sel)
                crs_pkg::MODE_POINT: begin
                    coef[0] = -u3 + 2 * u2 * ONE16 - u * ONE32;
                    coef[1] = 3 * u3 - 5 * u2 * ONE16 + 2 * ONE48;
                    coef[2] = -3 * u3 + 4 * u2 * ONE16 + u * ONE32;
                    coef[3] = u3 - u2 * ONE16;
                end
                crs_pkg::MODE_SLOPE: begin
                    coef[0] = -3 * u2 * ONE16 + 4 * u * ONE32 - ONE48;
                    coef[1] = 9 * u2 * ONE16 - 10 * u * ONE32;
                    coef[2] = -9 * u2 * ONE16 + 8 * u * ONE32 + ONE48;
                    coef[3] = 3 * u2 * ONE16 - 2 * u * ONE32;
                end
                default: begin
                    coef[0] = -6 * u * ONE32 + 4 * ONE48;
                    coef[1] = 18 * u * ONE32 - 10 * ONE48;
                    coef[2] = -18 * u * ONE32 + 8 * ONE48;
                    coef[3] = 6 * u * ONE32 - 2 * ONE48;
                end
            endcase
            // Neighbors clamp at both ends of the table.
            k[0] = (seg > 0) ? seg - 1 : 0;
            k[1] = seg;
            k[2] = seg + 1;
            k[3] = (seg + 2 < n - 1) ? seg + 2 : n - 1;
            sx = 0;
            sy = 0;
            for (int i = 0; i < 4; i++) begin
                coef[i] = round_shift(coef[i], 17);
                sx += coef[i] * longint'(shadow_x[k[i] % TABLE_SIZE]);
                sy += coef[i] * longint'(shadow_y[k[i] % TABLE_SIZE]);
            end
            sx = round_shift(sx, 32);
            sy = round_shift(sy, 32);
            if (sx > SAT_MAX) begin
                r.rx = SAT_MAX[31:0]; r.sat = 1'b1;
            end else if (sx < SAT_MIN) begin
                r.rx = SAT_MIN[31:0]; r.sat = 1'b1;
            end else begin
                r.rx = sx[31:0];
            end
            if (sy > SAT_MAX) begin
                r.ry = SAT_MAX[31:0]; r.sat = 1'b1;
            end else if (sy < SAT_MIN) begin
                r.ry = SAT_MIN[31:0]; r.sat = 1'b1;
            end else begin
                r.ry = sy[31:0];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued items; on each accepted transaction the
    // shadow table is updated (load) or the expected result queued (eval).
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (in_flight.op == crs_pkg::OP_LOAD) begin
                    if (in_flight.idx < TABLE_SIZE) begin
                        shadow_x[in_flight.idx] = int'($signed(in_flight.px));
                        shadow_y[in_flight.idx] = int'($signed(in_flight.py));
                    end
                end else begin
                    expected_curve = {expected_curve, spline_predict(in_flight)};
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (item_queue.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
                    in_flight = item_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, in_flight.sel, in_flight.tp, in_flight.py,
                                      in_flight.px, in_flight.idx};
                    s_axis_tuser  <= in_flight.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink ready: random stalls, plus one long hold on request so the
    // output queue fills and the block has to back-pressure its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_req && !hold_taken) begin
                hold_left  = SINK_HOLD;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 10);
            end
        end
    end

    task automatic flag_error(string what, longint want, longint got);
        if (error_count < 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
        error_count++;
    endtask

    // Monitor: every result transaction is checked against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_curve_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_curve.size() == 0) begin
                flag_error("result with nothing expected, out_x", 0,
                           $signed(m_axis_tdata[31:0]));
            end else begin
                want = expected_curve.pop_front();
                if (m_axis_tdata[31:0] !== want.rx)
                    flag_error("out_x", want.rx, $signed(m_axis_tdata[31:0]));
                if (m_axis_tdata[63:32] !== want.ry)
                    flag_error("out_y", want.ry, $signed(m_axis_tdata[63:32]));
                if (m_axis_tuser[0] !== want.sat)
                    flag_error("saturated", want.sat, m_axis_tuser[0]);
                if (m_axis_tuser[1] !== want.few)
                    flag_error("too_few_points", want.few, m_axis_tuser[1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Wait until the block is empty; loads give no result, so allow the
    // pipeline depth after the last result before touching the register.
    // Checked mid-cycle so the driver's work at the clock edge has settled.
    task automatic wait_drained();
        while (item_queue.size() != 0 || s_axis_tvalid || expected_curve.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of point_count, then read it back.
    task automatic set_point_count(logic [crs_pkg::CNT_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {crs_pkg::REG_POINT_COUNT, 2'b00};
        pwdata  <= {25'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        shadow_count = int'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[crs_pkg::CNT_W-1:0] !== value)
            flag_error("point_count readback", value, prdata[crs_pkg::CNT_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Fully random item; callers override the fields they care about.
    function automatic t_spline_item random_item();
        t_spline_item it;
        it.op  = ($urandom_range(9) < 7) ? crs_pkg::OP_EVAL : crs_pkg::OP_LOAD;
        it.idx = crs_pkg::IDX_W'($urandom_range(TABLE_SIZE - 1));
        it.px  = crs_pkg::PT_W'($urandom);
        it.py  = crs_pkg::PT_W'($urandom);
        // Coordinate extremes now and then.
        if ($urandom_range(9) == 0) it.px = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
        if ($urandom_range(9) == 0) it.py = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
        case ($urandom_range(9))
            0, 1:    it.tp = crs_pkg::T_W'($urandom);           // full range, clamps
            2:       it.tp = crs_pkg::T_W'(($urandom_range(1) ? 65536 : 0)
                                           - $urandom_range(2));
            default: it.tp = crs_pkg::T_W'($urandom_range(65536));
        endcase
        it.sel = ($urandom_range(9) == 0) ? crs_pkg::MODE_UNUSED
                                          : crs_pkg::MODE_W'($urandom_range(2));
        return it;
    endfunction

    task automatic add_load(int idx, int x, int y);
        t_spline_item it;
        it     = random_item();
        it.op  = crs_pkg::OP_LOAD;
        it.idx = crs_pkg::IDX_W'(idx);
        it.px  = crs_pkg::PT_W'(x);
        it.py  = crs_pkg::PT_W'(y);
        item_queue = {item_queue, it};
    endtask

    task automatic add_eval(int t, logic [crs_pkg::MODE_W-1:0] sel);
        t_spline_item it;
        it     = random_item();
        it.op  = crs_pkg::OP_EVAL;
        it.tp  = crs_pkg::T_W'(t);
        it.sel = sel;
        item_queue = {item_queue, it};
    endtask

    // One random phase at a given point count; the table is fully written
    // by then, so any index may be loaded or read.
    task automatic random_phase(logic [crs_pkg::CNT_W-1:0] cnt, int n_items);
        wait_drained();
        set_point_count(cnt);
        for (int i = 0; i < n_items; i++)
            item_queue = {item_queue, random_item()};
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            shadow_x[i] = 0;
            shadow_y[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Count left at its reset value of zero: every mode flags too few.
        add_eval($urandom_range(65536), crs_pkg::MODE_POINT);
        add_eval($urandom_range(65536), crs_pkg::MODE_SLOPE);
        add_eval($urandom_range(65536), crs_pkg::MODE_CURVE);
        add_eval($urandom_range(65536), crs_pkg::MODE_UNUSED);

        // Smallest usable curve, coordinate extremes in the points.
        wait_drained();
        set_point_count(4);
        add_load(0, 24'sh7FFFFF, 24'sh800000);
        add_load(1, 24'sh800000, 24'sh7FFFFF);
        add_load(2, 0, -1);
        add_load(3, 1, 24'sh7FFFFF);
        add_load(TABLE_SIZE - 1, 24'sh800000, 24'sh800000);
        add_eval(0, crs_pkg::MODE_POINT);
        add_eval(65536, crs_pkg::MODE_POINT);
        add_eval(-131072, crs_pkg::MODE_SLOPE);         // clamps to zero
        add_eval(131071, crs_pkg::MODE_CURVE);          // clamps to one
        add_eval(32768, crs_pkg::MODE_POINT);
        add_eval(32768, crs_pkg::MODE_SLOPE);
        add_eval(32768, crs_pkg::MODE_CURVE);
        add_eval(32768, crs_pkg::MODE_UNUSED);          // unused mode gives zero, no flags
        add_eval(1, crs_pkg::MODE_POINT);
        add_eval(65535, crs_pkg::MODE_SLOPE);
        add_eval(65535, crs_pkg::MODE_CURVE);

        // Fill the whole table in order while evaluating the first segment.
        wait_drained();
        for (int i = 0; i < TABLE_SIZE; i++) begin
            add_load(i, $urandom, $urandom);
            if (i % 2 == 1)
                add_eval($urandom_range(65536), crs_pkg::MODE_W'($urandom_range(3)));
        end

        // Full table with one long sink stall while the source keeps offering.
        wait_drained();
        hold_req <= 1'b1;
        random_phase(crs_pkg::CNT_W'(TABLE_SIZE), 50);

        // Count above the table size, no idling on either side.
        wait_drained();
        calm = 1'b1;
        random_phase(127, 40);
        wait_drained();
        calm = 1'b0;

        random_phase(5, 30);
        random_phase(3, 20);
        random_phase(0, 15);
        random_phase(100, 30);
        random_phase(1, 15);
        random_phase(crs_pkg::CNT_W'($urandom_range(6, TABLE_SIZE - 1)), 30);
        random_phase(4, 30);
        random_phase(crs_pkg::CNT_W'($urandom_range(4, TABLE_SIZE)), 25);

        wait_drained();
        if (error_count == 0 && expected_curve.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #(5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
